// ----- rtl/ppdd_pkg.sv -----
// ----------------------------------------------------------------------------
// ppdd_pkg
// Shared types, constants and helpers of the ping-pong damped delay.
// ----------------------------------------------------------------------------
package ppdd_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int DAMP_EXTRA    = 8;
    localparam int DAMPED_W      = SAMPLE_BITS + DAMP_EXTRA;
    localparam int CFG_W         = 16;
    localparam int CFG_INDEX_W   = 2;
    localparam int DEPTH_DEFAULT = 65536;

    localparam int Q_FRAC        = 16;
    localparam int FB_SHIFT      = Q_FRAC + DAMP_EXTRA;

    // shared multiplier: signed (damped-diff or damped) x unsigned Q0.16 coefficient
    localparam int MUL_A_W       = DAMPED_W + 1;
    localparam int MUL_B_W       = CFG_W + 1;
    localparam int PROD_W        = MUL_A_W + MUL_B_W;

    // input plus feedback term before saturation
    localparam int SUM_W         = SAMPLE_BITS + 3;

    localparam logic [CFG_W-1:0] MIN_DELAY        = CFG_W'(10);
    localparam logic [CFG_W-1:0] FEEDBACK_CAP     = CFG_W'(62259);
    localparam logic [CFG_W-1:0] DELAY_RESET      = CFG_W'(4800);
    localparam logic [CFG_W-1:0] FEEDBACK_RESET   = CFG_W'(0);
    localparam logic [CFG_W-1:0] DAMP_COEF_RESET  = CFG_W'(45875);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DELAY_LENGTH     = 2'd0,
        REG_FEEDBACK_GAIN    = 2'd1,
        REG_DAMP_COEFFICIENT = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_TAP,
        ST_DAMP_L,
        ST_DAMP_R,
        ST_FB_R,
        ST_FB_L,
        ST_WRITE
    } state_t;

    typedef enum logic [1:0] {
        MUL_DAMP_L,
        MUL_DAMP_R,
        MUL_FB_R,
        MUL_FB_L
    } mul_sel_t;

    typedef struct packed {
        logic     load;        // input transaction taken
        logic     rd_en;       // issue store read
        logic     tap_cap;     // read data valid, capture taps
        logic     mul_en;      // product register loads
        mul_sel_t mul_sel;
        logic     damp_l_upd;
        logic     damp_r_upd;
        logic     wr_cap;      // capture right store value
        logic     commit;      // write stores, advance pointer, present result
    } ppdd_ctl_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] in_left;
        logic signed [SAMPLE_BITS-1:0] in_right;
    } ppdd_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] delayed_left;
        logic signed [SAMPLE_BITS-1:0] delayed_right;
    } ppdd_out_t;

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'((1 << (SAMPLE_BITS - 1)) - 1);
        lo = -hi - SUM_W'(1);
        if (v > hi)
        begin
            return hi[SAMPLE_BITS-1:0];
        end
        else if (v < lo)
        begin
            return lo[SAMPLE_BITS-1:0];
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

endpackage

// ----- rtl/ping_pong_damped_delay.sv -----
// ----------------------------------------------------------------------------
// ping_pong_damped_delay
// Stereo ping-pong feedback delay with a one-pole lowpass in the feedback path.
// ----------------------------------------------------------------------------
// Each input transaction carries one stereo sample pair and produces one pair
// of delayed taps read delay_length samples back (clamped to 10..DEPTH-1).
// An item runs through the states READ, TAP, DAMP_L, DAMP_R, FB_R, FB_L and
// WRITE; the result is registered at the commit in WRITE. These states go to
// one store read, then four products through a single shared multiplier (two
// lowpass steps, two feedback scalings), then the store write; the block takes
// no new item during that time, and the last step waits while the output
// register is still full. Results sit in an output register, so the next item
// is taken while a finished pair waits. Store entries never written since
// reset read as zero via the write pointer and a wrap flag, so no clearing
// pass is needed. Configuration writes are taken every cycle and should be
// issued only while the block is idle.
module ping_pong_damped_delay
    import ppdd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  ppdd_in_t               in_data,

    output logic                   out_valid,
    input  logic                   out_ready,
    output ppdd_out_t              out_data,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CW    = (PTR_W > CFG_W ? PTR_W : CFG_W) + 1;

    // configuration
    logic [CFG_W-1:0] delay_length_reg;
    logic [CFG_W-1:0] feedback_gain_reg;
    logic [CFG_W-1:0] damp_coefficient_reg;

    // state
    logic                       wrapped_reg;
    logic [PTR_W-1:0]           ptr_reg;
    logic [PTR_W-1:0]           ptr_next;
    logic signed [DAMPED_W-1:0] damped_l_reg;
    logic signed [DAMPED_W-1:0] damped_r_reg;

    // per-item working registers
    ppdd_in_t                      in_reg;
    logic [PTR_W-1:0]              rd_addr_reg;
    logic [PTR_W-1:0]              rd_addr_next;
    logic                          tap_ok_reg;
    logic signed [SAMPLE_BITS-1:0] tap_l_reg;
    logic signed [SAMPLE_BITS-1:0] tap_r_reg;
    logic signed [SAMPLE_BITS-1:0] wr_val_reg;
    logic signed [SAMPLE_BITS-1:0] wl_val;

    logic      out_valid_reg;
    ppdd_out_t out_data_reg;

    ppdd_ctl_t ctl;

    logic [CW-1:0]    d_ext;
    logic [CW-1:0]    d_lim;
    logic [PTR_W-1:0] d_clamped;
    logic [CFG_W-1:0] fb_clamped;

    logic signed [MUL_A_W-1:0] op_a;
    logic signed [MUL_B_W-1:0] op_b;
    logic signed [PROD_W-1:0]  prod_reg;

    logic [SAMPLE_BITS-1:0] rdata_l;
    logic [SAMPLE_BITS-1:0] rdata_r;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_length_reg     <= DELAY_RESET;
            feedback_gain_reg    <= FEEDBACK_RESET;
            damp_coefficient_reg <= DAMP_COEF_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DELAY_LENGTH:     delay_length_reg     <= cfg_data;
                REG_FEEDBACK_GAIN:    feedback_gain_reg    <= cfg_data;
                REG_DAMP_COEFFICIENT: damp_coefficient_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // delay and gain limits
    always_comb
    begin
        d_lim = CW'(DEPTH - 1);
        d_ext = CW'(delay_length_reg);
        if (delay_length_reg < MIN_DELAY)
        begin
            d_ext = CW'(MIN_DELAY);
        end
        else if (d_ext > d_lim)
        begin
            d_ext = d_lim;
        end
        d_clamped  = d_ext[PTR_W-1:0];
        fb_clamped = (feedback_gain_reg > FEEDBACK_CAP) ? FEEDBACK_CAP : feedback_gain_reg;
    end

    always_comb
    begin
        if (ptr_reg >= d_clamped)
        begin
            rd_addr_next = ptr_reg - d_clamped;
        end
        else
        begin
            rd_addr_next = PTR_W'(CW'(ptr_reg) + CW'(DEPTH) - CW'(d_clamped));
        end
        ptr_next = (ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : ptr_reg + PTR_W'(1);
    end

    // shared multiplier operand select
    always_comb
    begin
        case (ctl.mul_sel)
            MUL_DAMP_L:
            begin
                op_a = MUL_A_W'(signed'({tap_l_reg, {DAMP_EXTRA{1'b0}}}))
                       - MUL_A_W'(damped_l_reg);
                op_b = {1'b0, damp_coefficient_reg};
            end
            MUL_DAMP_R:
            begin
                op_a = MUL_A_W'(signed'({tap_r_reg, {DAMP_EXTRA{1'b0}}}))
                       - MUL_A_W'(damped_r_reg);
                op_b = {1'b0, damp_coefficient_reg};
            end
            MUL_FB_R:
            begin
                op_a = MUL_A_W'(damped_l_reg);
                op_b = {1'b0, fb_clamped};
            end
            MUL_FB_L:
            begin
                op_a = MUL_A_W'(damped_r_reg);
                op_b = {1'b0, fb_clamped};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    ppdd_mul u_mul (
        .clk      (clk),
        .en       (ctl.mul_en),
        .op_a     (op_a),
        .op_b     (op_b),
        .prod_reg (prod_reg)
    );

    ppdd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_busy (out_valid_reg && !out_ready),
        .in_ready (in_ready),
        .ctl      (ctl)
    );

    assign wl_val = sat_sample(SUM_W'(in_reg.in_left) + SUM_W'(prod_reg >>> FB_SHIFT));

    ppdd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_left_store (
        .clk   (clk),
        .we    (ctl.commit),
        .waddr (ptr_reg),
        .wdata (wl_val),
        .re    (ctl.rd_en),
        .raddr (rd_addr_reg),
        .rdata (rdata_l)
    );

    ppdd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_right_store (
        .clk   (clk),
        .we    (ctl.commit),
        .waddr (ptr_reg),
        .wdata (wr_val_reg),
        .re    (ctl.rd_en),
        .raddr (rd_addr_reg),
        .rdata (rdata_r)
    );

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            in_reg      <= in_data;
            rd_addr_reg <= rd_addr_next;
        end
        if (ctl.rd_en)
        begin
            // before the first wrap only addresses below the pointer hold data
            tap_ok_reg <= wrapped_reg || (rd_addr_reg < ptr_reg);
        end
        if (ctl.tap_cap)
        begin
            tap_l_reg <= tap_ok_reg ? signed'(rdata_l) : '0;
            tap_r_reg <= tap_ok_reg ? signed'(rdata_r) : '0;
        end
        if (ctl.wr_cap)
        begin
            wr_val_reg <= sat_sample(SUM_W'(in_reg.in_right) + SUM_W'(prod_reg >>> FB_SHIFT));
        end
        if (ctl.commit)
        begin
            out_data_reg.delayed_left  <= tap_l_reg;
            out_data_reg.delayed_right <= tap_r_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            damped_l_reg  <= '0;
            damped_r_reg  <= '0;
            ptr_reg       <= '0;
            wrapped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.damp_l_upd)
            begin
                damped_l_reg <= damped_l_reg + DAMPED_W'(prod_reg >>> Q_FRAC);
            end
            if (ctl.damp_r_upd)
            begin
                damped_r_reg <= damped_r_reg + DAMPED_W'(prod_reg >>> Q_FRAC);
            end
            if (ctl.commit)
            begin
                ptr_reg <= ptr_next;
                if (ptr_reg == PTR_W'(DEPTH - 1))
                begin
                    wrapped_reg <= 1'b1;
                end
            end
            if (ctl.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // busy after taking an input until the result is committed
    a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an item is in flight");

    // a commit always leaves a result pending
    a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |=> out_valid)
        else $error("committed result not presented");

    // never overwrite a result that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |-> (!out_valid || out_ready))
        else $error("result overwritten before transfer");

    // once the store has wrapped every entry holds written data
    a_wrap_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        wrapped_reg |=> wrapped_reg)
        else $error("wrap flag dropped");

endmodule

// ----- rtl/ppdd_ram.sv -----
// ----------------------------------------------------------------------------
// ppdd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ppdd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/ppdd_mul.sv -----
// ----------------------------------------------------------------------------
// ppdd_mul
// Shared signed multiplier with registered product, reused for every
// lowpass and feedback product of a sample.
// ----------------------------------------------------------------------------
module ppdd_mul
    import ppdd_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [MUL_A_W-1:0] op_a,
    input  logic signed [MUL_B_W-1:0] op_b,
    output logic signed [PROD_W-1:0]  prod_reg
);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
        end
    end

endmodule

// ----- rtl/ppdd_ctrl.sv -----
// ----------------------------------------------------------------------------
// ppdd_ctrl
// Sequencer: read taps, run the four multiplies, write back, hand off result.
// ----------------------------------------------------------------------------
module ppdd_ctrl
    import ppdd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      out_busy,
    output logic      in_ready,
    output ppdd_ctl_t ctl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        ctl        = '0;
        ctl.mul_sel = MUL_DAMP_L;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                ctl.rd_en  = 1'b1;
                state_next = ST_TAP;
            end
            ST_TAP:
            begin
                ctl.tap_cap = 1'b1;
                state_next  = ST_DAMP_L;
            end
            ST_DAMP_L:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MUL_DAMP_L;
                state_next  = ST_DAMP_R;
            end
            ST_DAMP_R:
            begin
                ctl.damp_l_upd = 1'b1;
                ctl.mul_en     = 1'b1;
                ctl.mul_sel    = MUL_DAMP_R;
                state_next     = ST_FB_R;
            end
            ST_FB_R:
            begin
                // left damped state is fresh here; it feeds the right store
                ctl.damp_r_upd = 1'b1;
                ctl.mul_en     = 1'b1;
                ctl.mul_sel    = MUL_FB_R;
                state_next     = ST_FB_L;
            end
            ST_FB_L:
            begin
                ctl.wr_cap  = 1'b1;
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MUL_FB_L;
                state_next  = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (!out_busy)
                begin
                    ctl.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
